@@ rtl/u8u16_pkg.sv @@
`default_nettype none

package u8u16_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int CP_W    = 21;
    localparam int REM_W   = 2;

    // result queue depth: one waiting result plus the most one byte can give
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = 3;

    // decode constants
    localparam logic [UNIT_W-1:0] MIN_SIZE     = 16'd2;
    localparam logic [UNIT_W-1:0] SIZE_RESET   = 16'hFFFF;
    localparam logic [CP_W-1:0]   SUPPLEMENTAL = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

    // one result transaction
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_terminator;
        logic [UNIT_W-1:0] unit_count;
    } t_res;

    // results produced by one byte
    typedef struct packed {
        logic [1:0]              cnt;
        t_res [MAX_RES-1:0]      res;
    } t_dec_out;

endpackage

`default_nettype wire

@@ rtl/u8u16_if.sv @@
`default_nettype none

// input byte channel
interface u8u16_byte_if import u8u16_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// result channel
interface u8u16_unit_if import u8u16_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              is_terminator;
    logic [UNIT_W-1:0] unit_count;

    modport source (output valid, output code_unit, output is_terminator,
                    output unit_count, input ready);
    modport sink   (input valid, input code_unit, input is_terminator,
                    input unit_count, output ready);
endinterface

// configuration write channel
interface u8u16_cfg_if import u8u16_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] buffer_size;

    modport source (output valid, output buffer_size, input ready);
    modport sink   (input valid, input buffer_size, output ready);
endinterface

`default_nettype wire

@@ rtl/u8u16_dec.sv @@
`default_nettype none

module u8u16_dec import u8u16_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    u8u16_cfg_if.sink              i_cfg,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_take,
    output t_dec_out               o_dec
);

    logic [UNIT_W-1:0] r_bs;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [CP_W-1:0]   r_cp, n_cp;
    logic              r_four, n_four;
    logic [UNIT_W-1:0] r_uw, n_uw;

    logic [UNIT_W-1:0] limit;
    logic [CP_W-1:0]   merged;
    logic [CP_W-1:0]   e_cp;
    logic              e_four;
    logic              emit;
    logic              term;
    logic              pair;
    logic [CP_W-1:0]   v;
    logic [1:0]        e_n;
    logic [UNIT_W-1:0] uw_after;
    t_res              term_res;

    assign i_cfg.ready = 1'b1;

    // buffer size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= SIZE_RESET;
        end else if (i_cfg.valid) begin
            r_bs <= i_cfg.buffer_size;
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_cp   <= '0;
            r_four <= 1'b0;
            r_uw   <= '0;
        end else if (i_take) begin
            r_rem  <= n_rem;
            r_cp   <= n_cp;
            r_four <= n_four;
            r_uw   <= n_uw;
        end
    end

    // continuation merge at the slot picked by the remaining count
    always_comb begin
        case (r_rem)
            2'd3:    merged = r_cp | {3'b0, i_byte[5:0], 12'b0};
            2'd2:    merged = r_cp | {9'b0, i_byte[5:0], 6'b0};
            default: merged = r_cp | {15'b0, i_byte[5:0]};
        endcase
    end

    // byte decode and next state
    always_comb begin
        n_rem    = r_rem;
        n_cp     = r_cp;
        n_four   = r_four;
        n_uw     = r_uw;
        emit     = 1'b0;
        term     = 1'b0;
        e_cp     = r_cp;
        e_four   = r_four;
        limit    = ((r_bs < MIN_SIZE) ? MIN_SIZE : r_bs) - MIN_SIZE;

        if (i_byte == '0) begin
            // end of string, flush any open sequence
            emit = (r_rem != '0);
            term = 1'b1;
        end else if (r_rem != '0) begin
            e_cp  = merged;
            n_cp  = merged;
            n_rem = r_rem - 2'd1;
            emit  = (r_rem == 2'd1);
        end else if (r_uw < limit) begin
            if (!i_byte[7]) begin
                emit   = 1'b1;
                e_cp   = {13'b0, i_byte};
                e_four = 1'b0;
            end else if (i_byte[7:5] == 3'b110) begin
                n_cp   = {10'b0, i_byte[4:0], 6'b0};
                n_four = 1'b0;
                n_rem  = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_cp   = {5'b0, i_byte[3:0], 12'b0};
                n_four = 1'b0;
                n_rem  = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_cp   = {i_byte[2:0], 18'b0};
                n_four = 1'b1;
                n_rem  = 2'd3;
            end
        end

        pair     = emit && e_four && (e_cp >= SUPPLEMENTAL);
        v        = e_cp - SUPPLEMENTAL;
        e_n      = emit ? (pair ? 2'd2 : 2'd1) : 2'd0;
        uw_after = r_uw + {14'b0, e_n};

        if (emit) begin
            n_uw   = uw_after;
            n_rem  = '0;
            n_cp   = '0;
            n_four = 1'b0;
        end
        if (term) begin
            n_uw   = '0;
            n_rem  = '0;
            n_cp   = '0;
            n_four = 1'b0;
        end

        // pack the results in order
        term_res.code_unit     = '0;
        term_res.is_terminator = 1'b1;
        term_res.unit_count    = uw_after;

        o_dec.res = '0;
        if (pair) begin
            o_dec.res[0].code_unit = HI_SURR_BASE + {5'b0, v[20:10]};
            o_dec.res[1].code_unit = LO_SURR_BASE + {6'b0, v[9:0]};
        end else begin
            o_dec.res[0].code_unit = e_cp[UNIT_W-1:0];
        end
        if (term) begin
            o_dec.res[e_n] = term_res;
        end
        o_dec.cnt = e_n + {1'b0, term};
    end

endmodule

`default_nettype wire

@@ rtl/utf8_to_utf16_stream_decoder.sv @@
// channel   | dir | payload                                  | accepted when
// ----------+-----+------------------------------------------+--------------------------
// i_in      | in  | in_byte[7:0]                             | i_in.valid & i_in.ready
// o_out     | out | code_unit[15:0], is_terminator,          | o_out.valid & o_out.ready
//           |     | unit_count[15:0]                         |
// i_cfg     | in  | buffer_size[15:0]                        | i_cfg.valid & i_cfg.ready
//
// one byte is decoded in the cycle it is accepted; its zero to three results enter a
// four-entry result queue. while o_out is ready, results leave one per cycle and a byte
// per cycle is sustained while each byte gives at most one result. input ready is high
// while the queue holds at most one result. i_cfg is always ready. synchronous active-low
// reset clears the queue and the sequence state and sets buffer_size to 65535.
`default_nettype none

module utf8_to_utf16_stream_decoder import u8u16_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    u8u16_byte_if.sink    i_in,
    u8u16_unit_if.source  o_out,
    u8u16_cfg_if.sink     i_cfg
);

    t_dec_out           dec;
    logic               take;
    logic               pop;
    logic [Q_CNT_W-1:0] base;
    logic [Q_CNT_W-1:0] j;
    t_res               r_slot [Q_DEPTH];
    t_res               n_slot [Q_DEPTH];
    logic [Q_CNT_W-1:0] r_n, n_n;

    assign i_in.ready = (r_n <= Q_CNT_W'(1));
    assign take       = i_in.valid && i_in.ready;
    assign pop        = (r_n != '0) && o_out.ready;
    assign base       = r_n - {{(Q_CNT_W-1){1'b0}}, pop};

    u8u16_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_byte  (i_in.in_byte),
        .i_take  (take),
        .o_dec   (dec)
    );

    // queue shift on pop and fill behind the remaining entries
    always_comb begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            n_slot[i] = r_slot[i];
        end
        if (pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_slot[i] = r_slot[i+1];
            end
        end
        j = '0;
        for (int i = 0; i < Q_DEPTH; i++) begin
            j = Q_CNT_W'(i) - base;
            if (take && (Q_CNT_W'(i) >= base) && (j < {1'b0, dec.cnt})) begin
                n_slot[i] = dec.res[j[1:0]];
            end
        end
        n_n = base + (take ? {1'b0, dec.cnt} : '0);
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    // queue fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else begin
            r_n <= n_n;
        end
    end

    // head of queue drives the result channel
    assign o_out.valid         = (r_n != '0);
    assign o_out.code_unit     = r_slot[0].code_unit;
    assign o_out.is_terminator = r_slot[0].is_terminator;
    assign o_out.unit_count    = r_slot[0].unit_count;

endmodule

`default_nettype wire
